// ===== rtl/core/cc8_pkg.sv =====
// Shared types, constants and helper functions for the ChaCha8 keystream XOR core.
`default_nettype none

package cc8_pkg;

  localparam int BLOCK_BYTES = 64;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam logic [2:0] REG_KEY_0_7   = 3'd0;
  localparam logic [2:0] REG_KEY_8_15  = 3'd1;
  localparam logic [2:0] REG_KEY_16_23 = 3'd2;
  localparam logic [2:0] REG_KEY_24_31 = 3'd3;
  localparam logic [2:0] REG_NONCE     = 3'd4;
  localparam logic [2:0] REG_CTR_LOW   = 3'd5;
  localparam logic [2:0] REG_CTR_HIGH  = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } cc8_in_t;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       last_out;
  } cc8_out_t;

  typedef struct packed {
    logic [7:0][31:0] key_words;
    logic [1:0][31:0] nonce_words;
    logic [31:0]      ctr_high;
  } cc8_cfg_t;

  typedef struct packed {
    logic       start;
    logic [31:0] ctr_low;
  } cc8_gen_req_t;

  typedef struct packed {
    logic       en;
    logic [3:0] addr;
  } cc8_rd_req_t;

  typedef struct packed {
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] c;
    logic [3:0] d;
  } cc8_qr_sel_t;

  // Word indexes of the four column and four diagonal quarter rounds.
  function automatic cc8_qr_sel_t qr_select(input logic [2:0] q);
    cc8_qr_sel_t s;
    unique case (q)
      3'd0: s = '{a: 4'd0, b: 4'd4, c: 4'd8,  d: 4'd12};
      3'd1: s = '{a: 4'd1, b: 4'd5, c: 4'd9,  d: 4'd13};
      3'd2: s = '{a: 4'd2, b: 4'd6, c: 4'd10, d: 4'd14};
      3'd3: s = '{a: 4'd3, b: 4'd7, c: 4'd11, d: 4'd15};
      3'd4: s = '{a: 4'd0, b: 4'd5, c: 4'd10, d: 4'd15};
      3'd5: s = '{a: 4'd1, b: 4'd6, c: 4'd11, d: 4'd12};
      3'd6: s = '{a: 4'd2, b: 4'd7, c: 4'd8,  d: 4'd13};
      3'd7: s = '{a: 4'd3, b: 4'd4, c: 4'd9,  d: 4'd14};
    endcase
    return s;
  endfunction

  function automatic logic [31:0] init_word(input cc8_cfg_t cfg, input logic [31:0] ctr_low,
                                            input logic [3:0] idx);
    logic [31:0] w;
    unique case (idx)
      4'd0:  w = SIGMA0;
      4'd1:  w = SIGMA1;
      4'd2:  w = SIGMA2;
      4'd3:  w = SIGMA3;
      4'd4:  w = cfg.key_words[0];
      4'd5:  w = cfg.key_words[1];
      4'd6:  w = cfg.key_words[2];
      4'd7:  w = cfg.key_words[3];
      4'd8:  w = cfg.key_words[4];
      4'd9:  w = cfg.key_words[5];
      4'd10: w = cfg.key_words[6];
      4'd11: w = cfg.key_words[7];
      4'd12: w = ctr_low;
      4'd13: w = cfg.ctr_high;
      4'd14: w = cfg.nonce_words[0];
      4'd15: w = cfg.nonce_words[1];
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cc8_ksgen.sv =====
// Keystream block generator built around a 16-word state memory.
`default_nettype none

module cc8_ksgen
  import cc8_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cc8_gen_req_t gen_req,
  input  wire cc8_cfg_t     cfg,
  input  wire cc8_rd_req_t  rd_req,
  output logic [31:0]       rd_data,
  output logic              busy
);

  localparam int DR_W = (DOUBLE_ROUNDS > 2) ? $clog2(DOUBLE_ROUNDS) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_RD_AB = 3'd2;
  localparam logic [2:0] ST_RD_CD = 3'd3;
  localparam logic [2:0] ST_LATCH = 3'd4;
  localparam logic [2:0] ST_MIX   = 3'd5;
  localparam logic [2:0] ST_WR    = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]      state;
  logic [4:0]      cnt;
  logic [2:0]      qr;
  logic [DR_W-1:0] dr;
  logic [31:0]     ctr_low;
  logic [31:0]     wa, wb, wc, wd;

  logic [31:0] mem [16];
  logic [31:0] rda, rdb;

  cc8_qr_sel_t sel;
  logic        rd_en_a, rd_en_b, wr_en;
  logic [3:0]  rd_addr_a, rd_addr_b, wr_addr, fin_idx;
  logic [31:0] wr_data;
  logic [31:0] sum_ab, sum_cd, x_d, x_b;

  assign sel     = qr_select(qr);
  assign fin_idx = cnt[3:0] - 4'd1;
  assign sum_ab  = wa + wb;
  assign sum_cd  = wc + wd;
  assign x_d     = wd ^ sum_ab;
  assign x_b     = wb ^ sum_cd;
  assign rd_data = rda;
  assign busy    = (state != ST_IDLE);

  always_comb begin
    rd_en_a   = 1'b0;
    rd_en_b   = 1'b0;
    rd_addr_a = '0;
    rd_addr_b = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    unique case (state)
      ST_IDLE: begin
        rd_en_a   = rd_req.en;
        rd_addr_a = rd_req.addr;
      end
      ST_LOAD: begin
        wr_en   = 1'b1;
        wr_addr = cnt[3:0];
        wr_data = init_word(cfg, ctr_low, cnt[3:0]);
      end
      ST_RD_AB: begin
        rd_en_a   = 1'b1;
        rd_en_b   = 1'b1;
        rd_addr_a = sel.a;
        rd_addr_b = sel.b;
      end
      ST_RD_CD: begin
        rd_en_a   = 1'b1;
        rd_en_b   = 1'b1;
        rd_addr_a = sel.c;
        rd_addr_b = sel.d;
      end
      ST_WR: begin
        wr_en = 1'b1;
        unique case (cnt[1:0])
          2'd0: begin
            wr_addr = sel.a;
            wr_data = wa;
          end
          2'd1: begin
            wr_addr = sel.b;
            wr_data = wb;
          end
          2'd2: begin
            wr_addr = sel.c;
            wr_data = wc;
          end
          2'd3: begin
            wr_addr = sel.d;
            wr_data = wd;
          end
        endcase
      end
      ST_FIN: begin
        rd_en_a   = !cnt[4];
        rd_addr_a = cnt[3:0];
        wr_en     = (cnt != 5'd0);
        wr_addr   = fin_idx;
        wr_data   = init_word(cfg, ctr_low, fin_idx) + rda;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en_a) begin
      rda <= mem[rd_addr_a];
    end
    if (rd_en_b) begin
      rdb <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      qr    <= '0;
      dr    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (gen_req.start) begin
            state <= ST_LOAD;
            cnt   <= '0;
          end
        end
        ST_LOAD: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd15) begin
            state <= ST_RD_AB;
            cnt   <= '0;
            qr    <= '0;
            dr    <= '0;
          end
        end
        ST_RD_AB: state <= ST_RD_CD;
        ST_RD_CD: state <= ST_LATCH;
        ST_LATCH: begin
          state <= ST_MIX;
          cnt   <= '0;
        end
        ST_MIX: begin
          cnt <= cnt + 5'd1;
          if (cnt[1:0] == 2'd3) begin
            state <= ST_WR;
            cnt   <= '0;
          end
        end
        ST_WR: begin
          cnt <= cnt + 5'd1;
          if (cnt[1:0] == 2'd3) begin
            cnt   <= '0;
            qr    <= qr + 3'd1;
            state <= ST_RD_AB;
            if (qr == 3'd7) begin
              dr <= dr + DR_W'(1);
              if (dr == DR_W'(DOUBLE_ROUNDS - 1)) begin
                state <= ST_FIN;
              end
            end
          end
        end
        ST_FIN: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd16) begin
            state <= ST_IDLE;
            cnt   <= '0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && gen_req.start) begin
      ctr_low <= gen_req.ctr_low;
    end
    if (state == ST_RD_CD) begin
      wa <= rda;
      wb <= rdb;
    end
    if (state == ST_LATCH) begin
      wc <= rda;
      wd <= rdb;
    end
    if (state == ST_MIX) begin
      unique case (cnt[1:0])
        2'd0: begin
          wa <= sum_ab;
          wd <= {x_d[15:0], x_d[31:16]};
        end
        2'd1: begin
          wc <= sum_cd;
          wb <= {x_b[19:0], x_b[31:20]};
        end
        2'd2: begin
          wa <= sum_ab;
          wd <= {x_d[23:0], x_d[31:24]};
        end
        2'd3: begin
          wc <= sum_cd;
          wb <= {x_b[24:0], x_b[31:25]};
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/chacha8_keystream_xor_core.sv =====
// Top level of the byte-serial ChaCha8 keystream XOR core.
// A byte whose keystream block is present moves through the s1 stage and the result register.
// The first byte of each block waits for the block to be generated and read back from the state
// memory.
// Within a block the core takes and returns one byte per cycle unless res_ready stalls it.
// Synchronous reset clears the configuration, byte position, block index and handshakes.
`default_nettype none

module chacha8_keystream_xor_core
  import cc8_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        msg_valid,
  output logic             msg_ready,
  input  wire cc8_in_t     msg,
  output logic             res_valid,
  input  wire logic        res_ready,
  output cc8_out_t         res,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  cc8_cfg_t     cfg;
  logic [31:0]  ctr_low_start;
  logic [5:0]   byte_position;
  logic [31:0]  block_index;
  logic         ks_ready;

  logic         s1_valid;
  logic         s1_rd;
  logic [7:0]   s1_data;
  logic         s1_last;
  logic [5:0]   s1_pos;

  cc8_gen_req_t gen_req;
  cc8_rd_req_t  rd_req;
  logic [31:0]  rd_data;
  logic         gen_busy;
  logic         msg_acc, s1_move, s1_fetch;
  logic [7:0]   ks_byte;

  assign cfg_ready = 1'b1;
  assign msg_acc   = msg_valid && msg_ready;
  assign s1_move   = s1_valid && s1_rd && (!res_valid || res_ready);
  assign s1_fetch  = s1_valid && !s1_rd && !gen_busy;
  assign msg_ready = !gen_busy && (!s1_valid || s1_move);

  assign gen_req.start   = msg_acc && !ks_ready;
  assign gen_req.ctr_low = ctr_low_start ^ block_index;
  assign rd_req.en       = (msg_acc && ks_ready) || s1_fetch;
  assign rd_req.addr     = msg_acc ? byte_position[5:2] : s1_pos[5:2];

  always_comb begin
    unique case (s1_pos[1:0])
      2'd0: ks_byte = rd_data[7:0];
      2'd1: ks_byte = rd_data[15:8];
      2'd2: ks_byte = rd_data[23:16];
      2'd3: ks_byte = rd_data[31:24];
    endcase
  end

  cc8_ksgen #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_ksgen (
    .clk     (clk),
    .rst     (rst),
    .gen_req (gen_req),
    .cfg     (cfg),
    .rd_req  (rd_req),
    .rd_data (rd_data),
    .busy    (gen_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg           <= '0;
      ctr_low_start <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY_0_7:   cfg.key_words[1:0]  <= cfg_data;
        REG_KEY_8_15:  cfg.key_words[3:2]  <= cfg_data;
        REG_KEY_16_23: cfg.key_words[5:4]  <= cfg_data;
        REG_KEY_24_31: cfg.key_words[7:6]  <= cfg_data;
        REG_NONCE:     cfg.nonce_words     <= cfg_data;
        REG_CTR_LOW:   ctr_low_start       <= cfg_data[31:0];
        REG_CTR_HIGH:  cfg.ctr_high        <= cfg_data[31:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      block_index   <= '0;
      ks_ready      <= 1'b0;
      s1_valid      <= 1'b0;
      s1_rd         <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      if (msg_acc) begin
        s1_valid <= 1'b1;
        s1_rd    <= ks_ready;
        if (msg.last_byte) begin
          byte_position <= '0;
          block_index   <= '0;
          ks_ready      <= 1'b0;
        end else if (byte_position == 6'(BLOCK_BYTES - 1)) begin
          byte_position <= '0;
          block_index   <= block_index + 32'd1;
          ks_ready      <= 1'b0;
        end else begin
          byte_position <= byte_position + 6'd1;
          ks_ready      <= 1'b1;
        end
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end else if (s1_fetch) begin
        s1_rd <= 1'b1;
      end
      if (s1_move) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (msg_acc) begin
      s1_data <= msg.data_byte;
      s1_last <= msg.last_byte;
      s1_pos  <= byte_position;
    end
    if (s1_move) begin
      res.cipher_byte <= s1_data ^ ks_byte;
      res.last_out    <= s1_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cc8_chk.sv =====
// Port-level checker for the ChaCha8 keystream XOR core, bound to the top level.
`default_nettype none

module cc8_chk
  import cc8_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        msg_valid,
  input wire logic        msg_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire cc8_out_t    res,
  input wire logic        cfg_ready
);

  logic [1:0] outstanding;
  logic       in_acc, out_acc;

  assign in_acc  = msg_valid && msg_ready;
  assign out_acc = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_acc && !out_acc) begin
      outstanding <= outstanding + 2'd1;
    end else if (out_acc && !in_acc) begin
      outstanding <= outstanding - 2'd1;
    end
  end

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed or dropped while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> outstanding != 2'd0)
    else $error("result transaction without a pending input transaction");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    outstanding == 2'd2 && !res_ready |-> !msg_ready)
    else $error("input accepted with both internal slots occupied");

  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !res_valid && cfg_ready)
    else $error("result shown or configuration blocked right after reset");

endmodule

bind chacha8_keystream_xor_core cc8_chk u_cc8_chk (
  .clk       (clk),
  .rst       (rst),
  .msg_valid (msg_valid),
  .msg_ready (msg_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
